>>> hw/rtl/insertion_sorter_defines.svh
// Assertion macros shared by the insertion sorter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ISORT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("insertion sorter check failed");

// Condition must never be true outside reset.
`define ISORT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("insertion sorter forbidden condition");

`else

`define ISORT_ASSERT(lbl, clk, rst_n, prop)
`define ISORT_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies.
package isort_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEK,
		ST_CMP,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

>>> hw/rtl/isort_if.sv
// Valid/ready stream interfaces for the insertion sorter request channels.
// Depends on isort_pkg.
interface isort_in_if;
	logic                 valid;
	logic                 ready;
	isort_pkg::data_t     value;
	logic                 last_in;

	modport source (output valid, output value, output last_in, input ready);
	modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface isort_out_if;
	logic                 valid;
	logic                 ready;
	isort_pkg::data_t     sorted_value;
	logic                 last_out;
	logic                 overflow;

	modport source (output valid, output sorted_value, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input last_out, input overflow,
		output ready);
endinterface

>>> hw/rtl/insertion_sorter.sv
// Insertion sorter top level: sequencer, compare unit and element store.
// Depends on isort_pkg, isort_in_if/isort_out_if, isort_ram and the assert macros.
//
//  channel   dir  payload                               request when
//  samples   in   value[31:0] signed, last_in           valid & ready
//  results   out  sorted_value[31:0] signed,            valid & ready
//                 last_out, overflow
//
// Insert: one step per stored value greater than the new one (at most DEPTH-1);
//   one RAM read and one compare per step. A value offered while full is dropped.
// Flush after last_in: per result, one read then one output load.
// Reset clears sequencer, count, overflow flag and output valid; the store needs no clear.
// Output backpressure stalls only the flush; the output register lets the next
//   request in while the final result still waits.
`include "insertion_sorter_defines.svh"

module insertion_sorter #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	isort_in_if.sink    samples,
	isort_out_if.source results
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	isort_pkg::state_t state_q, state_d;

	// datapath registers
	logic [AW-1:0]       pos_q;    // hole the new value currently sits at
	logic [AW-1:0]       k_q;      // flush read index
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	isort_pkg::data_t    val_q;
	logic                last_q;

	// output register
	logic                out_vld_q;
	isort_pkg::data_t    out_data_q;
	logic                out_last_q;
	logic                out_ovf_q;

	// RAM port
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	isort_pkg::data_t    ram_wdata;
	logic [isort_pkg::DATA_W-1:0] ram_rdata;

	logic acc, full, placed, load, emit_last, greater;

	assign acc       = samples.valid && samples.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign greater   = ($signed(ram_rdata) > val_q);
	assign emit_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

	assign samples.ready        = (state_q == isort_pkg::ST_IDLE);
	assign results.valid        = out_vld_q;
	assign results.sorted_value = out_data_q;
	assign results.last_out     = out_last_q;
	assign results.overflow     = out_ovf_q;

	isort_ram #(
		.WIDTH (isort_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isort_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: one compare-and-shift step per cycle in ST_CMP. The read of the
	// next neighbor goes out in the same cycle the current one is shifted up.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = pos_q - AW'(1);
		placed    = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			isort_pkg::ST_IDLE: begin
				if (acc) begin
					if (full) begin
						// dropped; still flush if it closes the set
						state_d = samples.last_in ? isort_pkg::ST_EMIT_RD
							: isort_pkg::ST_IDLE;
					end else begin
						state_d = isort_pkg::ST_SEEK;
					end
				end
			end
			isort_pkg::ST_SEEK: begin
				if (pos_q == '0) begin
					state_d = isort_pkg::ST_PLACE;
				end else begin
					ram_re  = 1'b1;
					state_d = isort_pkg::ST_CMP;
				end
			end
			isort_pkg::ST_CMP: begin
				if (greater) begin
					// neighbor moves up one slot
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					if (pos_q == AW'(1)) begin
						state_d = isort_pkg::ST_PLACE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = pos_q - AW'(2);
					end
				end else begin
					ram_we  = 1'b1;
					placed  = 1'b1;
					state_d = last_q ? isort_pkg::ST_EMIT_RD : isort_pkg::ST_IDLE;
				end
			end
			isort_pkg::ST_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				placed    = 1'b1;
				state_d   = last_q ? isort_pkg::ST_EMIT_RD : isort_pkg::ST_IDLE;
			end
			isort_pkg::ST_EMIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
				state_d   = isort_pkg::ST_EMIT_LD;
			end
			isort_pkg::ST_EMIT_LD: begin
				if (!out_vld_q || results.ready) begin
					load    = 1'b1;
					state_d = emit_last ? isort_pkg::ST_IDLE : isort_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = isort_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load && emit_last) begin
				count_q <= '0;
			end else if (placed) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (acc && full) begin
				ovf_q <= 1'b1;
			end else if (load && emit_last) begin
				ovf_q <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			val_q  <= samples.value;
			last_q <= samples.last_in;
			pos_q  <= count_q[AW-1:0];
			k_q    <= '0;
		end else begin
			if (state_q == isort_pkg::ST_CMP && greater) begin
				pos_q <= pos_q - AW'(1);
			end
			if (load) begin
				k_q <= k_q + AW'(1);
			end
		end
		if (load) begin
			out_data_q <= ram_rdata;
			out_last_q <= emit_last;
			out_ovf_q  <= ovf_q;
		end
	end

	// checks
	`ISORT_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH))
	`ISORT_ASSERT(a_drop_flags, clk, arst_n, (acc && full) |=> ovf_q)
	`ISORT_ASSERT(a_load_src, clk, arst_n, $rose(out_vld_q) |-> $past(state_q) == isort_pkg::ST_EMIT_LD)
	`ISORT_ASSERT(a_flush_clears, clk, arst_n, (load && emit_last) |=> (count_q == '0 && !ovf_q))

endmodule

>>> hw/rtl/isort_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> verif/sorted_stream_checker.sv
// Scoreboard for the insertion sorter: predicts each sorted set from the accepted
// requests and compares every result leaving the block. Depends on isort_pkg, isort_if.
`timescale 1ns / 1ps

module sorted_stream_checker #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	isort_in_if  samples,
	isort_out_if results,
	output int   mismatches,
	output int   awaiting,
	output int   results_checked
);
	import isort_pkg::*;

	typedef struct packed {
		data_t value;
		logic  last_out;
		logic  overflow;
	} sorted_entry_t;

	sorted_entry_t due[$];    // predicted results, oldest first
	data_t         held[$];   // model of the element store, kept ascending
	logic          dropped;   // a value of the open set was lost
	sorted_entry_t want;
	sorted_entry_t got;

	// Insert behind every stored value that is not greater, so ties keep arrival order.
	function automatic void absorb(input data_t v, input logic last);
		int pos;
		if (held.size() >= DEPTH) begin
			dropped = 1'b1;
		end else begin
			pos = held.size();
			while (pos > 0 && held[pos-1] > v)
				pos--;
			held.insert(pos, v);
		end
		if (last) begin
			foreach (held[k])
				due.push_back('{held[k], logic'(k == held.size() - 1), dropped});
			held.delete();
			dropped = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			due.delete();
			held.delete();
			dropped = 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				got = '{results.sorted_value, results.last_out, results.overflow};
				if (due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result value=%0d last=%0b ovf=%0b",
							$realtime, got.value, got.last_out, got.overflow);
				end else begin
					want = due.pop_front();
					results_checked++;
					if (got.value !== want.value || got.last_out !== want.last_out ||
							got.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: value/last/ovf exp %0d/%0b/%0b got %0d/%0b/%0b",
								$realtime, want.value, want.last_out, want.overflow,
								got.value, got.last_out, got.overflow);
					end
				end
			end
			if (samples.valid && samples.ready)
				absorb(samples.value, samples.last_in);
		end
		awaiting = due.size();
	end

endmodule

>>> verif/tb.sv
// Top of the insertion sorter testbench: clock, reset, request stimulus and verdict.
// Depends on isort_pkg, isort_if, insertion_sorter and sorted_stream_checker.
`timescale 1ns / 1ps

module tb;
	import isort_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int ITEM_TARGET = 480;
	localparam int QUIET_CYCLES = 4 * DEPTH + 50;   // drain margin after the last result

	localparam data_t VAL_MIN = data_t'(32'h8000_0000);
	localparam data_t VAL_MAX = data_t'(32'h7fff_ffff);

	logic clk;
	logic arst_n;

	isort_in_if  samples_if ();
	isort_out_if results_if ();

	int mismatches;
	int awaiting;
	int results_checked;

	// Stimulus bookkeeping; the counts also feed the closing summary.
	int    items_sent;
	int    sets_sent;
	int    overflow_sets;
	data_t batch[$];   // values of the set being built; last one carries last_in
	bit    steady;     // when set, neither side inserts gaps for the current set
	int    hold;       // remaining stall cycles on the result side

	insertion_sorter #(.DEPTH(DEPTH)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	sorted_stream_checker #(.DEPTH(DEPTH)) u_sorted_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.samples         (samples_if),
		.results         (results_if),
		.mismatches      (mismatches),
		.awaiting        (awaiting),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses results.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Mostly no gap, sometimes a short gap, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Value mix: extremes, narrow ranges that produce ties, and full 32-bit noise.
	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return data_t'($signed($urandom_range(0, 8)) - 4);
			3, 4: return data_t'($urandom_range(0, 15));
			default: return data_t'($urandom);
		endcase
	endfunction

	// Result-side backpressure. Ready is registered at the clock edge like every input.
	initial begin
		hold = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				results_if.ready <= 1'b0;
				hold--;
			end else begin
				results_if.ready <= 1'b1;
				if (!steady)
					hold = pick_gap();
			end
		end
	end

	// Present one request and hold it until the handshake. valid stays high when
	// the next request follows directly, so it is never dropped and re-raised in one step.
	task automatic offer(input data_t v, input logic last);
		int gap;
		samples_if.valid   <= 1'b1;
		samples_if.value   <= v;
		samples_if.last_in <= last;
		do
			@(posedge clk);
		while (!samples_if.ready);
		items_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Send the staged set; the final value carries last_in and triggers the flush.
	// A set longer than DEPTH ends on a dropped value, which must still flush.
	task automatic flush_batch();
		steady = ($urandom_range(0, 3) == 0);
		if (batch.size() > DEPTH)
			overflow_sets++;
		foreach (batch[k])
			offer(batch[k], logic'(k == batch.size() - 1));
		sets_sent++;
		batch.delete();
	endtask

	task automatic stage_random(input int n);
		repeat (n) batch.push_back(pick_value());
	endtask

	initial begin
		int r;
		items_sent    = 0;
		sets_sent     = 0;
		overflow_sets = 0;
		steady        = 1'b0;
		arst_n                <= 1'b0;
		samples_if.valid      <= 1'b0;
		samples_if.value      <= '0;
		samples_if.last_in    <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a single-value set at the negative extreme.
		batch = '{VAL_MIN};
		flush_batch();
		// Both extremes and the values around zero and the limits.
		batch = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN + 1, VAL_MAX - 1};
		flush_batch();
		// Repeated values: ties must stay in place behind their equals.
		batch = '{7, 7, -3, 7, -3};
		flush_batch();
		// Strictly descending input, so each insert walks the whole stored run.
		batch = '{40, 30, 20, 10, 0, -10};
		flush_batch();

		// Store filled exactly, then overfilled with the flush on a dropped value.
		stage_random(DEPTH);
		flush_batch();
		stage_random(DEPTH + 2);
		flush_batch();

		// Random sets: mostly short, some mid-size, some around the store limit.
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				stage_random($urandom_range(1, 10));
			else if (r < 85)
				stage_random($urandom_range(11, DEPTH - 2));
			else
				stage_random($urandom_range(DEPTH - 1, DEPTH + 4));
			flush_batch();
		end
		samples_if.valid <= 1'b0;

		// Drain: wait for every predicted result, then watch for strays.
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);

		$display("Sent %0d values in %0d sets (%0d past the store limit); %0d results checked.",
			items_sent, sets_sent, overflow_sets, results_checked);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/isort_pkg.sv
hw/rtl/isort_if.sv
hw/rtl/isort_ram.sv
hw/rtl/insertion_sorter.sv
verif/sorted_stream_checker.sv
verif/tb.sv
